>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the checker file
// clk and arst_n must be visible where these are used
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define DSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// same-cycle implication
`define DSM_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define DSM_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/dsm_pkg.sv
// ---------------------------------------------------------------------------
// dsm_pkg
// types, field layout and constants of the dashboard signal monitor
// ---------------------------------------------------------------------------
package dsm_pkg;

	// number of heartbeat fields carried in one input word
	localparam int NODE_FIELDS   = 3;
	localparam int NUM_NODES_DEF = 3;
	localparam int HB_W          = 8;

	// input word layout
	localparam int S_DATA_W    = 128;
	localparam int RPM_LSB     = 0;
	localparam int TORQUE_LSB  = 16;
	localparam int TEMP_LSB    = 32;
	localparam int MV_LSB      = 42;
	localparam int MODE_LSB    = 58;
	localparam int FAULT_LSB   = 66;
	localparam int ESTOP_BIT   = 98;
	localparam int OVERC_BIT   = 99;
	localparam int HB_LSB      = 100;

	// output word layout
	localparam int M_DATA_W    = 40;
	localparam int SPEED_LSB   = 0;
	localparam int TSHOWN_LSB  = 12;
	localparam int TZONE_LSB   = 19;
	localparam int BZONE_LSB   = 21;
	localparam int WARN_LSB    = 23;
	localparam int MODE_O_LSB  = 28;
	localparam int ALIVE_LSB   = 36;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_GREEN_MAX  = 3'd0,
		REG_TEMP_YELLOW_MAX = 3'd1,
		REG_TEMP_ORANGE_MAX = 3'd2,
		REG_BATT_GREEN_MIN  = 3'd3,
		REG_BATT_YELLOW_MIN = 3'd4,
		REG_HB_TIMEOUT      = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ZONE_GREEN  = 2'd0,
		ZONE_YELLOW = 2'd1,
		ZONE_ORANGE = 2'd2,
		ZONE_RED    = 2'd3
	} zone_t;

	// warning mask bits
	localparam int WARN_CHECK_ENGINE = 0;
	localparam int WARN_TEMP         = 1;
	localparam int WARN_BATTERY      = 2;
	localparam int WARN_ESTOP        = 3;
	localparam int WARN_OVERCURRENT  = 4;

	localparam logic [9:0]  TEMP_GREEN_RST  = 10'd60;
	localparam logic [9:0]  TEMP_YELLOW_RST = 10'd80;
	localparam logic [9:0]  TEMP_ORANGE_RST = 10'd100;
	localparam logic [15:0] BATT_GREEN_RST  = 16'd12000;
	localparam logic [15:0] BATT_YELLOW_RST = 16'd11000;
	localparam logic [7:0]  HB_TIMEOUT_RST  = 8'd3;

	localparam logic [6:0]  TORQUE_MAX  = 7'd100;
	localparam logic [11:0] SPEED_MAX   = 12'd3932;
	localparam logic [7:0]  STALE_MAX   = 8'd255;

	// rpm*60/1000 = ((rpm*3)>>1)/25, the /25 done as multiply by 2^22/25 rounded up
	localparam int          SPEED_SHIFT = 22;
	localparam logic [17:0] SPEED_RECIP = 18'd167773;

endpackage

>>> rtl/dashboard_signal_monitor.sv
// ---------------------------------------------------------------------------
// dashboard_signal_monitor
// turns one word of vehicle signals per refresh tick into dashboard values
// ---------------------------------------------------------------------------
// usage
//   s_tvalid/s_tready/s_tdata take one word of raw signals per tick, and
//   m_tvalid/m_tready/m_tdata give one word of dashboard values for each
//   word taken, in order. cfg_valid/cfg_ready/cfg_index/cfg_data write the
//   zone thresholds and the heartbeat timeout; cfg_ready is always high and
//   writes belong in quiet periods with no word in flight.
//   a word taken at the input handshake passes through one input register,
//   then the result register, which drives m_tvalid and m_tdata.
//   throughput is one word per cycle while m_tready is high, with the speed
//   multiplier on the combinational path from input to result register.
//   the heartbeat monitors update when a word moves into the result register.
//   when the receiver stalls, the result holds, one more word waits in the
//   input register, and only then does s_tready drop.
//   reset clears both stages, loads the default thresholds and marks every
//   node alive with a zero last count.
// ---------------------------------------------------------------------------
module dashboard_signal_monitor #(
	parameter int NUM_NODES = dsm_pkg::NUM_NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// rpm 15:0, torque 31:16, temp 41:32, mv 57:42, mode 65:58,
	// fault 97:66, estop 98, overcurrent 99, hb0 107:100, hb1 115:108,
	// hb2 123:116, zero 127:124
	input  logic [dsm_pkg::S_DATA_W-1:0]      s_tdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// speed_kmh 11:0, torque_shown 18:12, temp_band 20:19,
	// batt_band 22:21, warning_mask 27:23, vehicle_mode_out 35:28,
	// node0_alive 36, node1_alive 37, node2_alive 38, zero 39
	output logic [dsm_pkg::M_DATA_W-1:0]      m_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dsm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dsm_pkg::*;

	localparam int WATCHED = (NUM_NODES < NODE_FIELDS) ? NUM_NODES : NODE_FIELDS;

	logic [9:0]  temp_green_q, temp_yellow_q, temp_orange_q;
	logic [15:0] batt_green_q, batt_yellow_q;
	logic [7:0]  hb_timeout_q;

	logic                in_valid_s1;
	logic [S_DATA_W-1:0] in_data_s1;
	logic                out_valid_s2;
	logic [M_DATA_W-1:0] out_data_s2;
	logic                advance;

	logic [HB_W-1:0] last_hb_q [WATCHED];
	logic [7:0]      stale_q   [WATCHED];
	logic [WATCHED-1:0] alive_q;
	logic [HB_W-1:0] last_hb_d [WATCHED];
	logic [7:0]      stale_d   [WATCHED];
	logic [WATCHED-1:0] alive_d;

	logic [15:0] rpm, torque, mv;
	logic [9:0]  temp;
	logic [17:0] rpm3;
	logic [34:0] speed_prod;
	logic [11:0] speed;
	logic [6:0]  torque_shown;
	zone_t       tzone, bzone;
	logic [4:0]  warn;
	logic [NODE_FIELDS-1:0] alive_out;
	logic [M_DATA_W-1:0]    result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_green_q  <= TEMP_GREEN_RST;
			temp_yellow_q <= TEMP_YELLOW_RST;
			temp_orange_q <= TEMP_ORANGE_RST;
			batt_green_q  <= BATT_GREEN_RST;
			batt_yellow_q <= BATT_YELLOW_RST;
			hb_timeout_q  <= HB_TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TEMP_GREEN_MAX:  temp_green_q  <= cfg_data[9:0];
				REG_TEMP_YELLOW_MAX: temp_yellow_q <= cfg_data[9:0];
				REG_TEMP_ORANGE_MAX: temp_orange_q <= cfg_data[9:0];
				REG_BATT_GREEN_MIN:  batt_green_q  <= cfg_data;
				REG_BATT_YELLOW_MIN: batt_yellow_q <= cfg_data;
				REG_HB_TIMEOUT:      hb_timeout_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// result register frees up when empty or being taken
	assign advance  = !out_valid_s2 || m_tready;
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_data_s1 <= s_tdata;
		end
	end

	always_comb begin
		rpm    = in_data_s1[RPM_LSB +: 16];
		torque = in_data_s1[TORQUE_LSB +: 16];
		temp   = in_data_s1[TEMP_LSB +: 10];
		mv     = in_data_s1[MV_LSB +: 16];

		rpm3       = {2'b00, rpm} + {1'b0, rpm, 1'b0};
		speed_prod = 35'(rpm3[17:1]) * 35'(SPEED_RECIP);
		speed      = speed_prod[SPEED_SHIFT +: 12];

		torque_shown = (torque > 16'(TORQUE_MAX)) ? TORQUE_MAX : torque[6:0];

		if (temp <= temp_green_q) begin
			tzone = ZONE_GREEN;
		end else if (temp <= temp_yellow_q) begin
			tzone = ZONE_YELLOW;
		end else if (temp <= temp_orange_q) begin
			tzone = ZONE_ORANGE;
		end else begin
			tzone = ZONE_RED;
		end

		if (mv > batt_green_q) begin
			bzone = ZONE_GREEN;
		end else if (mv >= batt_yellow_q) begin
			bzone = ZONE_YELLOW;
		end else begin
			bzone = ZONE_RED;
		end

		warn                    = '0;
		warn[WARN_CHECK_ENGINE] = |in_data_s1[FAULT_LSB +: 32];
		warn[WARN_TEMP]         = (tzone == ZONE_ORANGE) || (tzone == ZONE_RED);
		warn[WARN_BATTERY]      = (bzone == ZONE_RED);
		warn[WARN_ESTOP]        = in_data_s1[ESTOP_BIT];
		warn[WARN_OVERCURRENT]  = in_data_s1[OVERC_BIT];
	end

	// per-node heartbeat watch, each node independent
	always_comb begin
		for (int i = 0; i < WATCHED; i++) begin
			last_hb_d[i] = last_hb_q[i];
			stale_d[i]   = stale_q[i];
			alive_d[i]   = alive_q[i];
			if (in_data_s1[HB_LSB + HB_W*i +: HB_W] != last_hb_q[i]) begin
				last_hb_d[i] = in_data_s1[HB_LSB + HB_W*i +: HB_W];
				stale_d[i]   = '0;
				alive_d[i]   = 1'b1;
			end else begin
				if (stale_q[i] != STALE_MAX) begin
					stale_d[i] = stale_q[i] + 8'd1;
				end
				if (stale_d[i] > hb_timeout_q) begin
					alive_d[i] = 1'b0;
				end
			end
		end
		alive_out = '0;
		alive_out[WATCHED-1:0] = alive_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WATCHED; i++) begin
				last_hb_q[i] <= '0;
				stale_q[i]   <= '0;
			end
			alive_q <= '1;
		end else if (in_valid_s1 && advance) begin
			for (int i = 0; i < WATCHED; i++) begin
				last_hb_q[i] <= last_hb_d[i];
				stale_q[i]   <= stale_d[i];
			end
			alive_q <= alive_d;
		end
	end

	always_comb begin
		result                          = '0;
		result[SPEED_LSB +: 12]         = speed;
		result[TSHOWN_LSB +: 7]         = torque_shown;
		result[TZONE_LSB +: 2]          = tzone;
		result[BZONE_LSB +: 2]          = bzone;
		result[WARN_LSB +: 5]           = warn;
		result[MODE_O_LSB +: 8]         = in_data_s1[MODE_LSB +: 8];
		result[ALIVE_LSB +: NODE_FIELDS] = alive_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid_s1) begin
			out_data_s2 <= result;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = out_data_s2;

endmodule

>>> rtl/dsm_checker.sv
// ---------------------------------------------------------------------------
// dsm_checker
// port-level checks on the dashboard signal monitor
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dsm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic [dsm_pkg::M_DATA_W-1:0]   m_tdata,
	input logic                           m_tvalid,
	input logic                           m_tready
);
	import dsm_pkg::*;

	logic stalled;
	logic ranges_ok;
	logic [6:0]  torque_o;
	logic [1:0]  bzone_o;
	logic [11:0] speed_o;

	assign stalled  = m_tvalid && !m_tready;
	assign torque_o = m_tdata[TSHOWN_LSB +: 7];
	assign bzone_o  = m_tdata[BZONE_LSB +: 2];
	assign speed_o  = m_tdata[SPEED_LSB +: 12];
	// battery never reports the orange code
	assign ranges_ok = (torque_o <= TORQUE_MAX) && (speed_o <= SPEED_MAX) &&
		(bzone_o != ZONE_ORANGE);

	`DSM_ASSERT_NXT(a_valid_held, stalled, m_tvalid, "result word dropped while stalled")
	`DSM_ASSERT_NXT(a_data_held, stalled, $stable(m_tdata), "result word changed while stalled")
	`DSM_ASSERT_IMP(a_ranges, m_tvalid, ranges_ok, "result field out of range")
	`DSM_ASSERT_IMP(a_empty_ready, !m_tvalid, s_tready, "input blocked with result stage empty")

endmodule

bind dashboard_signal_monitor dsm_checker u_dsm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

>>> bench/tb_dashboard_signal_monitor.sv
// ----------------------------------------------------------------------------
// tb_dashboard_signal_monitor
// self-checking bench for the dashboard signal monitor: sends vehicle signal
// words with random gaps and output stalls, computes every dashboard word
// from its own copy of thresholds and heartbeat state, and compares fields
// ----------------------------------------------------------------------------
module tb_dashboard_signal_monitor;
	import dsm_pkg::*;

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 4;
	localparam int MAX_REPORTS    = 10;
	localparam int NODES          = NUM_NODES_DEF;
	localparam int REROLL_EVERY   = 40;
	localparam int unsigned KMH_MUL = 60;
	localparam int unsigned KMH_DIV = 1000;
	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct {
		logic [15:0] rpm;
		logic [15:0] torque;
		logic [9:0]  temp;
		logic [15:0] mv;
		logic [7:0]  mode;
		logic [31:0] fault;
		logic        estop;
		logic        overc;
		logic [NODE_FIELDS-1:0][HB_W-1:0] hb;
	} signals_t;

	typedef struct {
		logic [11:0]            speed;
		logic [6:0]             torque;
		zone_t                  tzone;
		zone_t                  bzone;
		logic [4:0]             warn;
		logic [7:0]             mode;
		logic [NODE_FIELDS-1:0] alive;
	} dash_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// shadow of the block's registers and heartbeat monitors
	logic [9:0]      temp_green_lim, temp_yellow_lim, temp_orange_lim;
	logic [15:0]     batt_green_lim, batt_yellow_lim;
	logic [7:0]      hb_timeout;
	logic [HB_W-1:0] hb_last  [NODES];
	logic [7:0]      hb_stale [NODES];
	logic            hb_alive [NODES];
	logic [NODE_FIELDS-1:0][HB_W-1:0] hb_sent;

	dash_t       dash_expected [$];
	dash_t       got_dash, want_dash;
	string       bad_fields;
	logic [M_DATA_W-1:ALIVE_LSB+NODE_FIELDS] pad_bits;
	bit          in_gaps    = 1'b0;
	bit          out_stalls = 1'b0;
	int unsigned rdy_hold   = 0;
	int unsigned idle_cycles = 0;
	int unsigned words_sent = 0, words_checked = 0, mismatch_count = 0, settings_count = 0;

	always #CLK_HALF clk = ~clk;

	dashboard_signal_monitor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic int unsigned gap_len();
		if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// a value within two of base, clipped to the field range
	function automatic int unsigned near_value(int unsigned base, int unsigned lim);
		int unsigned v;
		v = base + $urandom_range(0, 4);
		v = (v < 2) ? 0 : v - 2;
		return (v > lim) ? lim : v;
	endfunction

	function automatic dash_t predict_dashboard(signals_t s);
		dash_t       d;
		int unsigned kmh;
		kmh = s.rpm;
		kmh = kmh * KMH_MUL / KMH_DIV;
		d.speed  = kmh[11:0];
		d.torque = (s.torque > TORQUE_MAX) ? TORQUE_MAX : s.torque[6:0];
		if (s.temp <= temp_green_lim) d.tzone = ZONE_GREEN;
		else if (s.temp <= temp_yellow_lim) d.tzone = ZONE_YELLOW;
		else if (s.temp <= temp_orange_lim) d.tzone = ZONE_ORANGE;
		else d.tzone = ZONE_RED;
		if (s.mv > batt_green_lim) d.bzone = ZONE_GREEN;
		else if (s.mv >= batt_yellow_lim) d.bzone = ZONE_YELLOW;
		else d.bzone = ZONE_RED;
		d.warn = '0;
		d.warn[WARN_CHECK_ENGINE] = (s.fault != 0);
		d.warn[WARN_TEMP]         = (d.tzone == ZONE_ORANGE) || (d.tzone == ZONE_RED);
		d.warn[WARN_BATTERY]      = (d.bzone == ZONE_RED);
		d.warn[WARN_ESTOP]        = s.estop;
		d.warn[WARN_OVERCURRENT]  = s.overc;
		d.mode  = s.mode;
		d.alive = '0;
		for (int n = 0; n < NODE_FIELDS; n++) begin
			if (n < NODES) begin
				if (s.hb[n] != hb_last[n]) begin
					hb_last[n]  = s.hb[n];
					hb_stale[n] = '0;
					hb_alive[n] = 1'b1;
				end else begin
					if (hb_stale[n] != STALE_MAX) hb_stale[n] = hb_stale[n] + 1'b1;
					if (hb_stale[n] > hb_timeout) hb_alive[n] = 1'b0;
				end
				d.alive[n] = hb_alive[n];
			end
		end
		return d;
	endfunction

	// mostly values around the current thresholds, heartbeats held or changed
	function automatic signals_t random_signals(logic [NODE_FIELDS-1:0] hold);
		signals_t    s;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		s.rpm = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
		s.torque = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
		case ($urandom_range(0, 3))
			0: s.temp = 10'(near_value(temp_green_lim, 1023));
			1: s.temp = 10'(near_value(temp_yellow_lim, 1023));
			2: s.temp = 10'(near_value(temp_orange_lim, 1023));
			default: s.temp = 10'($urandom);
		endcase
		case ($urandom_range(0, 2))
			0: s.mv = 16'(near_value(batt_green_lim, 65535));
			1: s.mv = 16'(near_value(batt_yellow_lim, 65535));
			default: s.mv = 16'($urandom);
		endcase
		s.mode  = 8'($urandom);
		s.fault = ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom;
		s.estop = 1'($urandom);
		s.overc = 1'($urandom);
		for (int n = 0; n < NODE_FIELDS; n++)
			s.hb[n] = (hold[n] || $urandom_range(0, 4) < 3) ? hb_sent[n] : 8'($urandom);
		return s;
	endfunction

	task automatic send_signals(input signals_t s);
		int unsigned         gap;
		logic [S_DATA_W-1:0] w;
		gap = (in_gaps && $urandom_range(0, 2) == 0) ? gap_len() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w = '0;
		w[RPM_LSB +: 16]               = s.rpm;
		w[TORQUE_LSB +: 16]            = s.torque;
		w[TEMP_LSB +: 10]              = s.temp;
		w[MV_LSB +: 16]                = s.mv;
		w[MODE_LSB +: 8]               = s.mode;
		w[FAULT_LSB +: 32]             = s.fault;
		w[ESTOP_BIT]                   = s.estop;
		w[OVERC_BIT]                   = s.overc;
		w[HB_LSB +: NODE_FIELDS*HB_W]  = s.hb;
		s_tdata  <= w;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		hb_sent = s.hb;
		dash_expected.push_back(predict_dashboard(s));
		words_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (dash_expected.size() != 0) @(posedge clk);
	endtask

	// leaves cfg_valid high so back-to-back writes need no second assignment
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TEMP_GREEN_MAX:  temp_green_lim  = data[9:0];
			REG_TEMP_YELLOW_MAX: temp_yellow_lim = data[9:0];
			REG_TEMP_ORANGE_MAX: temp_orange_lim = data[9:0];
			REG_BATT_GREEN_MIN:  batt_green_lim  = data;
			REG_BATT_YELLOW_MIN: batt_yellow_lim = data;
			REG_HB_TIMEOUT:      hb_timeout      = data[7:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] tmp_g, tmp_y, tmp_o,
			bat_g, bat_y, hb_to);
		drain();
		write_reg(REG_TEMP_GREEN_MAX, tmp_g);
		write_reg(REG_TEMP_YELLOW_MAX, tmp_y);
		write_reg(REG_TEMP_ORANGE_MAX, tmp_o);
		write_reg(REG_BATT_GREEN_MIN, bat_g);
		write_reg(REG_BATT_YELLOW_MIN, bat_y);
		write_reg(REG_HB_TIMEOUT, hb_to);
		// writes to unused indexes must leave everything above untouched
		write_reg(REG_SPARE_A, 16'($urandom));
		write_reg(REG_SPARE_B, 16'($urandom));
		cfg_valid <= 1'b0;
		settings_count++;
	endtask

	task automatic program_ordered(input logic [CFG_DATA_W-1:0] hb_to);
		int unsigned g, y, o, bg, by;
		g  = $urandom_range(0, 400);
		y  = g + $urandom_range(0, 300);
		o  = y + $urandom_range(0, 300);
		bg = $urandom_range(9000, 14000);
		by = bg - $urandom_range(0, 3000);
		program_regs({6'($urandom), 10'(g)}, {6'($urandom), 10'(y)},
			{6'($urandom), 10'(o)}, 16'(bg), 16'(by), hb_to);
	endtask

	task automatic run_items(input int count, input logic [NODE_FIELDS-1:0] hold);
		for (int i = 0; i < count; i++) begin
			if (i % REROLL_EVERY == 0) begin
				in_gaps    = ($urandom_range(0, 3) != 0);
				out_stalls = ($urandom_range(0, 3) != 0);
			end
			send_signals(random_signals(hold));
		end
	endtask

	// reset thresholds, field extremes and heartbeat loss and recovery
	task automatic test_reset_values();
		logic [15:0] rpm_pts [5]    = '{16'd0, 16'd999, 16'd1000, 16'd16667, 16'hFFFF};
		logic [15:0] torque_pts [5] = '{16'd0, 16'd99, 16'd100, 16'd101, 16'hFFFF};
		logic [9:0]  temp_pts [8]   = '{10'd0, 10'd60, 10'd61, 10'd80, 10'd81, 10'd100,
			10'd101, 10'd1023};
		logic [15:0] mv_pts [6]     = '{16'd0, 16'd10999, 16'd11000, 16'd12000,
			16'd12001, 16'hFFFF};
		logic [31:0] fault_pts [3]  = '{32'h0, 32'h1, 32'hFFFF_FFFF};
		signals_t    s;
		in_gaps    = 1'b0;
		out_stalls = 1'b0;
		for (int i = 0; i < 16; i++) begin
			s.rpm    = rpm_pts[i % 5];
			s.torque = torque_pts[i % 5];
			s.temp   = temp_pts[i % 8];
			s.mv     = mv_pts[i % 6];
			s.mode   = (i % 2) ? 8'hFF : 8'h00;
			s.fault  = fault_pts[i % 3];
			s.estop  = i[0];
			s.overc  = i[1];
			// node0 stuck at its reset count for six words, then moving, node1 always moving,
			// node2 jumps once, goes stale, then recovers
			s.hb[0]  = (i < 6) ? 8'd0 : 8'(i);
			s.hb[1]  = 8'(i + 1);
			s.hb[2]  = (i < 12) ? 8'hFF : 8'h00;
			send_signals(s);
		end
	endtask

	// green limit above yellow above orange, junk in the data bits above the green, yellow and timeout registers
	task automatic test_threshold_order();
		logic [9:0]  temp_pts [8] = '{10'd99, 10'd100, 10'd101, 10'd200, 10'd201, 10'd500,
			10'd501, 10'd1023};
		logic [15:0] mv_pts [8]   = '{16'd0, 16'd4999, 16'd5000, 16'd5001, 16'd59999,
			16'd60000, 16'd60001, 16'hFFFF};
		signals_t    s;
		program_regs(16'hFDF4, 16'hFCC8, 16'h0064, 16'd5000, 16'd60000, 16'hFF02);
		in_gaps    = 1'b1;
		out_stalls = 1'b1;
		for (int i = 0; i < 8; i++) begin
			s      = random_signals('0);
			s.temp = temp_pts[i];
			s.mv   = mv_pts[i];
			send_signals(s);
		end
	endtask

	task automatic test_random_zones();
		for (int k = 0; k < 4; k++) begin
			if (k < 2) begin
				program_ordered((k == 0) ? 16'hFF00 : 16'($urandom_range(1, 6)));
			end else begin
				program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), {8'($urandom), 8'($urandom_range(1, 6))});
			end
			run_items(40, '0);
		end
	endtask

	task automatic test_register_extremes();
		program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		run_items(30, '0);
		program_regs(16'h03FF, 16'h03FF, 16'h03FF, 16'hFFFF, 16'hFFFF, 16'h00FE);
		run_items(30, '0);
	endtask

	// a timeout of 255 can never be exceeded; dropping to 254 then kills the
	// saturated nodes at once
	task automatic test_stale_saturation();
		signals_t s;
		program_ordered(16'hFFFF);
		s       = random_signals('0);
		s.hb[0] = ~hb_sent[0];
		s.hb[1] = ~hb_sent[1];
		send_signals(s);
		run_items(260, 3'b011);
		program_ordered(16'h00FE);
		run_items(30, 3'b011);
	endtask

	always @(posedge clk) begin
		if (rdy_hold != 0) begin
			rdy_hold <= rdy_hold - 1;
		end else if (out_stalls && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			rdy_hold <= gap_len() - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			got_dash.speed  = m_tdata[SPEED_LSB +: 12];
			got_dash.torque = m_tdata[TSHOWN_LSB +: 7];
			got_dash.tzone  = zone_t'(m_tdata[TZONE_LSB +: 2]);
			got_dash.bzone  = zone_t'(m_tdata[BZONE_LSB +: 2]);
			got_dash.warn   = m_tdata[WARN_LSB +: 5];
			got_dash.mode   = m_tdata[MODE_O_LSB +: 8];
			got_dash.alive  = m_tdata[ALIVE_LSB +: NODE_FIELDS];
			pad_bits        = m_tdata[M_DATA_W-1:ALIVE_LSB+NODE_FIELDS];
			if (dash_expected.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("dashboard word %h with nothing outstanding", m_tdata);
			end else begin
				want_dash = dash_expected.pop_front();
				words_checked++;
				bad_fields = "";
				if (got_dash.speed !== want_dash.speed) bad_fields = {bad_fields, " speed"};
				if (got_dash.torque !== want_dash.torque) bad_fields = {bad_fields, " torque"};
				if (got_dash.tzone !== want_dash.tzone) bad_fields = {bad_fields, " temp_band"};
				if (got_dash.bzone !== want_dash.bzone) bad_fields = {bad_fields, " batt_band"};
				if (got_dash.warn !== want_dash.warn) bad_fields = {bad_fields, " warnings"};
				if (got_dash.mode !== want_dash.mode) bad_fields = {bad_fields, " mode"};
				if (got_dash.alive !== want_dash.alive) bad_fields = {bad_fields, " alive"};
				if (pad_bits !== '0) bad_fields = {bad_fields, " pad"};
				if (bad_fields != "") begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("word %0d differs in%s", words_checked, bad_fields);
						$display("  expected spd=%0d trq=%0d tz=%0d bz=%0d warn=%b mode=%0d alive=%b",
							want_dash.speed, want_dash.torque, want_dash.tzone,
							want_dash.bzone, want_dash.warn, want_dash.mode, want_dash.alive);
						$display("  actual   spd=%0d trq=%0d tz=%0d bz=%0d warn=%b mode=%0d alive=%b",
							got_dash.speed, got_dash.torque, got_dash.tzone,
							got_dash.bzone, got_dash.warn, got_dash.mode, got_dash.alive);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("no word moved for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, dash_expected.size());
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		temp_green_lim  = TEMP_GREEN_RST;
		temp_yellow_lim = TEMP_YELLOW_RST;
		temp_orange_lim = TEMP_ORANGE_RST;
		batt_green_lim  = BATT_GREEN_RST;
		batt_yellow_lim = BATT_YELLOW_RST;
		hb_timeout      = HB_TIMEOUT_RST;
		for (int n = 0; n < NODES; n++) begin
			hb_last[n]  = '0;
			hb_stale[n] = '0;
			hb_alive[n] = 1'b1;
		end
		hb_sent = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_threshold_order();
		test_random_zones();
		test_register_extremes();
		test_stale_saturation();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d signal words in, %0d dashboard words compared", words_sent, words_checked);
		$display("%0d register settings incl. unordered and extreme limits, stale count saturation",
			settings_count);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d bad dashboard words", mismatch_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
